// File: design/olada_pkg.sv
// Package for the ordered list block: sizes, opcode and status codes.
// Used by the channel interfaces and every module of the block.
`default_nettype none
package olada_pkg;

  // List capacity and field widths
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int STS_W = 3;
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_HEAD    = 3'd0,
    ST_TAIL    = 3'd1,
    ST_DELETED = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BOUNDS  = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  // Command from the controller to the datapath
  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

// File: design/olada_if.sv
// Valid/ready channel interfaces for operations in and results out.
// Depends on olada_pkg for widths.
`default_nettype none
interface olada_in_if;
  import olada_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface olada_out_if;
  import olada_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STS_W-1:0]        status;
  logic signed [VAL_W-1:0] removed_value;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, output status, output removed_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input entry_count,
                  output ready);
endinterface
`default_nettype wire

// File: design/olada_ctrl.sv
// Controller for the ordered list: handshake state machine that issues execute commands.
// Depends on olada_pkg.
`default_nettype none
module olada_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output olada_pkg::cmd_t     cmd
);
  import olada_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_HOLD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   xfer_in;

  // Take a new operation whenever the result register is free or being drained
  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign xfer_in   = in_valid && in_ready;
  assign out_valid = (state_r == S_HOLD);
  assign cmd.exec  = xfer_in;

  // Advance: hold while a result waits, drop to empty once it is taken
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_EMPTY: begin
        if (xfer_in) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready && !xfer_in) state_nxt = S_EMPTY;
      end
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A result held but not taken must still be held next cycle
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // Execute only with a free or draining result slot
  a_exec_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid || out_ready))
    else $error("execute would overwrite a waiting result");

  // Each execute yields a valid result in the next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("execute did not produce a result");

endmodule
`default_nettype wire

// File: design/olada_dp.sv
// Datapath for the ordered list: entry shift chain, count and result register.
// Depends on olada_pkg.
`default_nettype none
module olada_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire olada_pkg::cmd_t               cmd,
  input  wire logic                          opcode,
  input  wire logic signed [olada_pkg::VAL_W-1:0] value,
  input  wire logic [olada_pkg::POS_W-1:0]   position,
  output logic [olada_pkg::STS_W-1:0]        status,
  output logic signed [olada_pkg::VAL_W-1:0] removed_value,
  output logic [olada_pkg::CNT_W-1:0]        entry_count
);
  import olada_pkg::*;

  logic [VAL_W-1:0] entries_r   [DEPTH];
  logic [VAL_W-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  status_t          status_r;
  status_t          status_nxt;
  logic [VAL_W-1:0] removed_r;
  logic [VAL_W-1:0] removed_nxt;

  logic             is_full;
  logic             is_empty;
  logic             in_bounds;
  logic             do_app;
  logic             do_del;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  // Decode the operation against the current count
  assign pos_ext   = CMP_W'(position);
  assign cnt_ext   = CMP_W'(count_r);
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign in_bounds = (pos_ext < cnt_ext);
  assign do_app    = (op_t'(opcode) == OP_APPEND) && !is_full;
  assign do_del    = (op_t'(opcode) == OP_DELETE) && !is_empty && in_bounds;

  // Pick status, removed value and new count
  always_comb begin
    removed_nxt = '0;
    count_nxt   = count_r;
    priority if (op_t'(opcode) == OP_APPEND) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = is_empty ? ST_HEAD : ST_TAIL;
        count_nxt  = count_r + 1'b1;
      end
    end else if (is_empty) begin
      status_nxt = ST_EMPTY;
    end else if (!in_bounds) begin
      status_nxt = ST_BOUNDS;
    end else begin
      status_nxt  = ST_DELETED;
      removed_nxt = entries_r[position[IDX_W-1:0]];
      count_nxt   = count_r - 1'b1;
    end
  end

  // Write the tail cell on append, shift later cells toward the head on delete
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
      if (do_app && (CNT_W'(i) == count_r)) begin
        entries_nxt[i] = value;
      end else if (do_del && (CMP_W'(i) >= pos_ext) && (i < DEPTH - 1)) begin
        entries_nxt[i] = entries_r[IDX_W'(i + 1)];
      end
    end
  end

  // Entries and result fields are payload: no reset
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      entries_r <= entries_nxt;
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign status        = status_r;
  assign removed_value = removed_r;
  assign entry_count   = count_r;

  // Count never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  // A successful delete shrinks the list by exactly one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && do_del) |=> (count_r == $past(count_r) - 1'b1))
    else $error("delete did not shrink the list by one");

  // A rejected operation leaves the count alone
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !do_app && !do_del) |=> (count_r == $past(count_r)))
    else $error("rejected operation changed the count");

endmodule
`default_nettype wire

// File: design/ordered_list_append_delete_at_index_top.sv
// Top level of the ordered list block: joins controller and datapath to the channels.
// Depends on olada_pkg, olada_if, olada_ctrl and olada_dp.
`default_nettype none
// Holds an ordered list of up to 16 signed 32-bit entries, head at position zero.
// Append writes the tail; delete removes the entry at a position and the later
// entries move one place toward the head, all cells shifting together.
// Every operation updates the shift chain and returns one result in
// the following cycle from the result register; a new operation is taken each
// cycle as long as the result side keeps up. Entry contents are not cleared by
// reset; only the count is, and only entries below the count ever reach the outputs.
module ordered_list_append_delete_at_index_top (
  input  wire logic clk,
  input  wire logic rst_n,
  olada_in_if.sink    in_ch,
  olada_out_if.source out_ch
);
  import olada_pkg::*;

  cmd_t cmd;

  // Handshake control
  olada_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // List storage and result fields
  olada_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .opcode        (in_ch.opcode),
    .value         (in_ch.value),
    .position      (in_ch.position),
    .status        (out_ch.status),
    .removed_value (out_ch.removed_value),
    .entry_count   (out_ch.entry_count)
  );

endmodule
`default_nettype wire

// File: tb/tb_ordered_list_append_delete_at_index_top.sv
// Testbench for the ordered list block: directed table, then random traffic,
// checked against table results and an in-bench list predictor. Depends on olada_pkg, olada_if
// and the ordered_list_append_delete_at_index_top design.
`default_nettype none
module tb_ordered_list_append_delete_at_index_top;
  import olada_pkg::*;

  localparam int N_RANDOM  = 800;
  localparam int HOLD_LEN  = 60;
  localparam int N_DIRECTED = 12;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] removed;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  // One row of the directed table; reps > 1 appends value, value+1, ...
  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    int                      reps;
    bit                      typed;
    list_result_t            res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  olada_in_if  in_ch ();
  olada_out_if out_ch ();

  ordered_list_append_delete_at_index_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state and the results still owed by the block
  logic signed [VAL_W-1:0] model_list[$];
  list_result_t            pending_results[$];

  int errors = 0;
  int accepted_ops = 0;
  int results_seen = 0;
  int status_tally[6];
  int burst_left = 0;
  bit hold_req = 1'b0;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{OP_DELETE, 32'sd0,          8'd0,   1, 1'b1, '{ST_EMPTY,   32'sd0,          5'd0}},
    '{OP_APPEND, 32'sh80000000,   8'd0,   1, 1'b1, '{ST_HEAD,    32'sd0,          5'd1}},
    '{OP_APPEND, 32'sh7FFFFFFF,   8'd0,   1, 1'b1, '{ST_TAIL,    32'sd0,          5'd2}},
    '{OP_DELETE, 32'sd0,          8'd2,   1, 1'b1, '{ST_BOUNDS,  32'sd0,          5'd2}},
    '{OP_DELETE, 32'sd0,          8'd0,   1, 1'b1, '{ST_DELETED, 32'sh80000000,   5'd1}},
    '{OP_DELETE, 32'sd0,          8'd0,   1, 1'b1, '{ST_DELETED, 32'sh7FFFFFFF,   5'd0}},
    '{OP_APPEND, -32'sd1,         8'd0,   1, 1'b1, '{ST_HEAD,    32'sd0,          5'd1}},
    '{OP_APPEND, 32'sd100,        8'd0,  15, 1'b0, '{ST_HEAD,    32'sd0,          5'd0}},
    '{OP_APPEND, 32'sd5,          8'd0,   1, 1'b1, '{ST_FULL,    32'sd0,          5'd16}},
    '{OP_DELETE, 32'sd0,          8'd255, 1, 1'b1, '{ST_BOUNDS,  32'sd0,          5'd16}},
    '{OP_DELETE, 32'sd0,          8'd15,  1, 1'b0, '{ST_HEAD,    32'sd0,          5'd0}},
    '{OP_DELETE, 32'sd0,          8'd0,   1, 1'b1, '{ST_DELETED, -32'sd1,         5'd14}}
  };

  always #2 clk = ~clk;

  // Apply one operation to the predicted list and return its result
  function automatic list_result_t list_apply(op_t op, logic signed [VAL_W-1:0] val,
                                              logic [POS_W-1:0] pos);
    list_result_t r;
    r.removed = '0;
    if (op == OP_APPEND) begin
      if (model_list.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        r.status = (model_list.size() == 0) ? ST_HEAD : ST_TAIL;
        model_list.push_back(val);
      end
    end else if (model_list.size() == 0) begin
      r.status = ST_EMPTY;
    end else if (int'(pos) >= model_list.size()) begin
      r.status = ST_BOUNDS;
    end else begin
      r.removed = model_list[pos];
      model_list.delete(int'(pos));
      r.status = ST_DELETED;
    end
    r.count = CNT_W'(model_list.size());
    return r;
  endfunction

  // Offer one operation in bursts with random gaps; return once it transfers
  task automatic send_op(input op_t op, input logic signed [VAL_W-1:0] val,
                         input logic [POS_W-1:0] pos, input bit typed,
                         input list_result_t typed_res);
    list_result_t pred;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid    = 1'b1;
    in_ch.opcode   = op;
    in_ch.value    = val;
    in_ch.position = pos;
    do @(posedge clk); while (!in_ch.ready);
    pred = list_apply(op, val, pos);
    pending_results.push_back(typed ? typed_res : pred);
    accepted_ops++;
    @(negedge clk);
  endtask

  // Receiver: switch stall patterns, honor a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int cyc;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = (cyc % 5 != 0);
      endcase
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d removed_value %0d entry_count %0d",
               out_ch.status, out_ch.removed_value, out_ch.entry_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.status <= ST_FULL) status_tally[want.status]++;
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          errors++;
        end
        if (out_ch.removed_value !== want.removed) begin
          $error("removed_value mismatch: expected %0d, actual %0d",
                 want.removed, out_ch.removed_value);
          errors++;
        end
        if (out_ch.entry_count !== want.count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 want.count, out_ch.entry_count);
          errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain, verdict
  initial begin
    list_result_t no_res;
    op_t op;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    int phase;
    int append_pct;
    no_res = '{ST_HEAD, '0, '0};
    phase = 0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_APPEND;
    in_ch.value    = '0;
    in_ch.position = '0;
    for (int s = 0; s < 6; s++) status_tally[s] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      for (int r = 0; r < dir_rows[i].reps; r++) begin
        send_op(dir_rows[i].op, dir_rows[i].value + r, dir_rows[i].pos,
                dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random traffic in fill, drain and balanced phases
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) phase = $urandom_range(0, 2);
      append_pct = (phase == 0) ? 75 : (phase == 1) ? 25 : 50;
      op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_DELETE;
      case ($urandom_range(0, 19))
        0: val = 32'sh80000000;
        1: val = 32'sh7FFFFFFF;
        2: val = -32'sd1;
        3: val = 32'sd0;
        default: val = $urandom;
      endcase
      if (model_list.size() > 0 && $urandom_range(0, 9) != 0)
        pos = POS_W'($urandom_range(0, model_list.size() - 1));
      else
        pos = POS_W'($urandom_range(0, 255));
      // Stall the result side while traffic keeps coming
      if (n == 200 || n == 550) hold_req = 1'b1;
      // Pause the sender until every result is back
      if (n == 400) begin
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_op(op, val, pos, 1'b0, no_res);
    end
    in_ch.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d operations, %0d results: head %0d, tail %0d, deleted %0d,",
             accepted_ops, results_seen, status_tally[ST_HEAD], status_tally[ST_TAIL],
             status_tally[ST_DELETED]);
    $display("  empty %0d, out of bounds %0d, full %0d; %0d mismatches",
             status_tally[ST_EMPTY], status_tally[ST_BOUNDS], status_tally[ST_FULL], errors);
    if (errors == 0) begin
      $display("ordered_list_append_delete_at_index_top test passed");
    end else begin
      $display("ordered_list_append_delete_at_index_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("ordered_list_append_delete_at_index_top test failed");
    $finish;
  end

endmodule
`default_nettype wire
